### rtl/core/bfcs_pkg.sv
// Shared types, codes and bank tables for the banked flash command sequencer.
package bfcs_pkg;

   // Request opcodes
   localparam logic [1:0] OPC_PROGRAM = 2'd0;
   localparam logic [1:0] OPC_ERASE   = 2'd1;
   localparam logic [1:0] OPC_EXIT    = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_POLL   = 2'd1;
   localparam logic [1:0] KIND_TOGGLE = 2'd2;
   localparam logic [1:0] KIND_SKIP   = 2'd3;

   // Command bus constants
   localparam logic [19:0] ADDR_UNLOCK1 = 20'h0AAAA;
   localparam logic [19:0] ADDR_UNLOCK2 = 20'h05555;
   localparam logic [19:0] ADDR_ZERO    = 20'h00000;
   localparam logic [7:0]  DATA_UNLOCK1 = 8'hAA;
   localparam logic [7:0]  DATA_UNLOCK2 = 8'h55;
   localparam logic [7:0]  DATA_PROGRAM = 8'hA0;
   localparam logic [7:0]  DATA_ERASE   = 8'h80;
   localparam logic [7:0]  DATA_SECTOR  = 8'h30;
   localparam logic [7:0]  DATA_RESET   = 8'hF0;

   // Absolute address map limits
   localparam logic [21:0] PROT_LOW    = 22'h1C0000;
   localparam logic [21:0] PROT_HIGH   = 22'h1DFFFF;
   localparam logic [21:0] SECT64_HIGH = 22'h1EFFFF;
   localparam logic [21:0] SECT32_HIGH = 22'h1F7FFF;
   localparam logic [21:0] SECT8_HIGH  = 22'h1FBFFF;
   localparam logic [21:0] SECT16_HIGH = 22'h1FFFFF;

   localparam logic [2:0] PROGRAM_LAST_STEP = 3'd4;
   localparam logic [2:0] ERASE_LAST_STEP   = 3'd7;

   typedef enum logic [1:0] {
      SEQ_PROGRAM,
      SEQ_ERASE,
      SEQ_EXIT,
      SEQ_SKIP
   } seq_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  bank;
      logic [19:0] offset;
      logic [7:0]  value;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [19:0] address;
      logic [7:0]  data;
      logic        last;
   } rsp_type;

   // Classified command passed from front to back
   typedef struct packed {
      seq_type     seq;
      logic [19:0] offset;
      logic [7:0]  value;
   } cmd_type;

   // Queue pop-side status seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   function automatic logic [20:0] bank_base(input logic [3:0] bank);
      logic [20:0] base;
      case (bank)
         4'd1:    base = 21'h180000;
         4'd2:    base = 21'h100000;
         4'd3:    base = 21'h000000;
         4'd4:    base = 21'h040000;
         4'd5:    base = 21'h080000;
         4'd6:    base = 21'h0C0000;
         4'd7:    base = 21'h000000;
         4'd8:    base = 21'h080000;
         4'd9:    base = 21'h000000;
         4'd10:   base = 21'h1C0000;
         default: base = 21'h000000;
      endcase
      return base;
   endfunction

   function automatic logic [20:0] bank_size(input logic [3:0] bank);
      logic [20:0] size;
      case (bank)
         4'd1, 4'd3, 4'd4, 4'd5, 4'd6, 4'd10: size = 21'h040000;
         4'd2, 4'd7, 4'd8:                     size = 21'h080000;
         4'd9:                                 size = 21'h100000;
         default:                              size = 21'h000000;
      endcase
      return size;
   endfunction

endpackage

### rtl/core/bfcs_front.sv
// Front end: accept requests, check bank, protection and sector boundary.
module bfcs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bfcs_pkg::req_type req_data,
   output logic              push_valid,
   output bfcs_pkg::cmd_type push_cmd,
   input  logic              q_full
);

   logic              ent_valid_ff, ent_valid_in;
   bfcs_pkg::cmd_type ent_ff, ent_in;
   logic              accept, push;
   logic [21:0]       abs_addr;
   logic              in_bank, in_prot, on_boundary, usable;

   assign req_stall  = ent_valid_ff && q_full;
   assign accept     = req_valid && !req_stall;
   assign push       = ent_valid_ff && !q_full;
   assign push_valid = ent_valid_ff;
   assign push_cmd   = ent_ff;

   always_comb begin
      abs_addr = {1'b0, bfcs_pkg::bank_base(req_data.bank)} + {2'b00, req_data.offset};
      in_bank  = {1'b0, req_data.offset} < bfcs_pkg::bank_size(req_data.bank);
      in_prot  = (abs_addr >= bfcs_pkg::PROT_LOW) && (abs_addr <= bfcs_pkg::PROT_HIGH);
      usable   = in_bank && !in_prot;
      if (abs_addr <= bfcs_pkg::SECT64_HIGH) begin
         on_boundary = (abs_addr[15:0] == '0);
      end else if (abs_addr <= bfcs_pkg::SECT32_HIGH) begin
         on_boundary = (abs_addr[14:0] == '0);
      end else if (abs_addr <= bfcs_pkg::SECT8_HIGH) begin
         on_boundary = (abs_addr[12:0] == '0);
      end else if (abs_addr <= bfcs_pkg::SECT16_HIGH) begin
         on_boundary = (abs_addr[13:0] == '0);
      end else begin
         on_boundary = 1'b0;
      end

      ent_in.offset = req_data.offset;
      ent_in.value  = req_data.value;
      case (req_data.opcode)
         bfcs_pkg::OPC_PROGRAM:
            ent_in.seq = usable ? bfcs_pkg::SEQ_PROGRAM : bfcs_pkg::SEQ_SKIP;
         bfcs_pkg::OPC_ERASE:
            ent_in.seq = (usable && on_boundary) ? bfcs_pkg::SEQ_ERASE : bfcs_pkg::SEQ_SKIP;
         bfcs_pkg::OPC_EXIT:
            ent_in.seq = bfcs_pkg::SEQ_EXIT;
         default:
            ent_in.seq = bfcs_pkg::SEQ_SKIP;
      endcase

      if (accept) begin
         ent_valid_in = 1'b1;
      end else if (push) begin
         ent_valid_in = 1'b0;
      end else begin
         ent_valid_in = ent_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ent_ff <= ent_in;
      end
   end

   // A held entry must not move while the queue is full
   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (ent_valid_ff && q_full) |=> (ent_valid_ff && $stable(ent_ff)))
      else $error("front entry changed while queue full");

   // Unusable program requests never reach the back end as programs
   a_skip_out_of_bank: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.opcode == bfcs_pkg::OPC_PROGRAM && !in_bank)
      |=> (ent_ff.seq == bfcs_pkg::SEQ_SKIP))
      else $error("out-of-bank program not skipped");

endmodule

### rtl/core/bfcs_queue.sv
// Small command queue between front and back ends.
module bfcs_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  bfcs_pkg::cmd_type    push_cmd,
   output logic                 full,
   output bfcs_pkg::q_head_type head,
   input  logic                 pop
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   bfcs_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push, do_pop;

   assign full       = (count_ff == FULL_COUNT);
   assign push       = push_valid && !full;
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count overflow");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

### rtl/core/bfcs_back.sv
// Back end: step through the flash bus sequence of each queued command.
module bfcs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bfcs_pkg::q_head_type head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bfcs_pkg::rsp_type    rsp_data
);

   bfcs_pkg::cmd_type cmd_ff, cmd_in;
   logic              busy_ff, busy_in;
   logic [2:0]        step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bfcs_pkg::rsp_type rsp_ff, gen;
   logic              load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign load      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop       = head.valid && (!busy_ff || (load && gen.last));

   // Build the bus operation for the current step
   always_comb begin
      gen.kind    = bfcs_pkg::KIND_WRITE;
      gen.address = bfcs_pkg::ADDR_ZERO;
      gen.data    = '0;
      gen.last    = 1'b0;
      case (cmd_ff.seq)
         bfcs_pkg::SEQ_PROGRAM: begin
            case (step_ff)
               3'd0: begin
                  gen.address = bfcs_pkg::ADDR_UNLOCK1;
                  gen.data    = bfcs_pkg::DATA_UNLOCK1;
               end
               3'd1: begin
                  gen.address = bfcs_pkg::ADDR_UNLOCK2;
                  gen.data    = bfcs_pkg::DATA_UNLOCK2;
               end
               3'd2: begin
                  gen.address = bfcs_pkg::ADDR_UNLOCK1;
                  gen.data    = bfcs_pkg::DATA_PROGRAM;
               end
               3'd3: begin
                  gen.address = cmd_ff.offset;
                  gen.data    = cmd_ff.value;
               end
               default: begin
                  gen.kind    = bfcs_pkg::KIND_POLL;
                  gen.address = cmd_ff.offset;
                  gen.data    = cmd_ff.value;
                  gen.last    = 1'b1;
               end
            endcase
         end
         bfcs_pkg::SEQ_ERASE: begin
            case (step_ff)
               3'd0, 3'd3: begin
                  gen.address = bfcs_pkg::ADDR_UNLOCK1;
                  gen.data    = bfcs_pkg::DATA_UNLOCK1;
               end
               3'd1, 3'd4: begin
                  gen.address = bfcs_pkg::ADDR_UNLOCK2;
                  gen.data    = bfcs_pkg::DATA_UNLOCK2;
               end
               3'd2: begin
                  gen.address = bfcs_pkg::ADDR_UNLOCK1;
                  gen.data    = bfcs_pkg::DATA_ERASE;
               end
               3'd5: begin
                  gen.address = cmd_ff.offset;
                  gen.data    = bfcs_pkg::DATA_SECTOR;
               end
               3'd6: begin
                  gen.kind = bfcs_pkg::KIND_TOGGLE;
               end
               default: begin
                  gen.data = bfcs_pkg::DATA_RESET;
                  gen.last = 1'b1;
               end
            endcase
         end
         bfcs_pkg::SEQ_EXIT: begin
            gen.data = bfcs_pkg::DATA_RESET;
            gen.last = 1'b1;
         end
         default: begin
            gen.kind = bfcs_pkg::KIND_SKIP;
            gen.last = 1'b1;
         end
      endcase
   end

   always_comb begin
      cmd_in  = cmd_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (pop) begin
         cmd_in  = head.cmd;
         busy_in = 1'b1;
         step_in = '0;
      end else if (load && gen.last) begin
         busy_in = 1'b0;
         step_in = '0;
      end else if (load) begin
         step_in = step_ff + 1'b1;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (load) begin
         rsp_ff <= gen;
      end
   end

   a_program_steps: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cmd_ff.seq == bfcs_pkg::SEQ_PROGRAM)
      |-> (step_ff <= bfcs_pkg::PROGRAM_LAST_STEP))
      else $error("program step out of range");

   a_step_restart: assert property (@(posedge clock) disable iff (reset)
      (load && gen.last) |=> (step_ff == '0))
      else $error("step counter did not restart after final operation");

endmodule

### rtl/core/banked_flash_command_sequencer.sv
// Top level of the banked flash command sequencer.
//
//   Channel  Direction  Handshake            Payload
//   req_*    in         req_valid/req_stall  bfcs_pkg::req_type (opcode, bank, offset, value)
//   rsp_*    out        rsp_valid/rsp_stall  bfcs_pkg::rsp_type (kind, address, data, last)
//
// One bus operation leaves per cycle while a command is in hand and rsp is not
// stalled; program has 5 steps, erase 8, exit and skipped requests 1, set by the
// step counter in the back end. After a request is accepted, its first result
// passes through the front register, a queue slot, the command register and the
// output register in that order.
// Reset is synchronous and active high; it empties the queue and both ends.
// A stall on rsp holds the output register; the queue keeps taking requests
// until it and the front register are full, then req_stall rises.
module banked_flash_command_sequencer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bfcs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bfcs_pkg::rsp_type rsp_data
);

   // Front to queue
   logic                 push_valid;
   bfcs_pkg::cmd_type    push_cmd;
   logic                 q_full;
   // Queue to back
   bfcs_pkg::q_head_type q_head;
   logic                 q_pop;

   // Classify each transaction: program, erase, exit or skip
   bfcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_full     (q_full)
   );

   // Decouple the front from the flash bus pace
   bfcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .head       (q_head),
      .pop        (q_pop)
   );

   // Drive the unlock, command, poll, toggle and reset operations in order
   bfcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
